// ===== rtl/core/kfc_pkg.sv =====
// ----------------------------------------------------------------------------
// kfc_pkg: shared types and constants for the k-mer frequency counter
// Holds command and register codes, bin store sizing and the memory request
// bundle passed between the top level and the bin store.
// ----------------------------------------------------------------------------
package kfc_pkg;

    // Longest counted word in bases
    localparam int K_MAX    = 8;
    // Bin index width: two bits per base
    localparam int BIN_W    = 2 * K_MAX;
    localparam int NUM_BINS = 1 << BIN_W;
    localparam int SHIFT_W  = $clog2(BIN_W);
    localparam int COUNT_W  = 32;
    localparam int RUN_W    = 4;
    localparam int KW_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Commands
    localparam logic [1:0] CMD_COUNT = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_0        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_1        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_2        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_3        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KMER_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_FASTEST = 3'd5;

    // Kind of result carried by the read stage
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_COUNT,
        RES_READ
    } res_kind_t;

    // One cycle of bin store traffic
    typedef struct packed {
        logic               rd_en;
        logic [BIN_W-1:0]   rd_addr;
        logic               wr_en;
        logic [BIN_W-1:0]   wr_addr;
        logic [COUNT_W-1:0] wr_data;
    } mem_req_t;

endpackage

// ===== rtl/core/kmer_frequency_counter.sv =====
// ----------------------------------------------------------------------------
// kmer_frequency_counter: k-mer counter over a nucleotide byte stream
// Maps bytes to two-bit bases, builds a packed window index and keeps a
// saturating 32-bit count per window in a single-port-write bin memory.
// ----------------------------------------------------------------------------
// Pipeline: a word passes the memory read stage, then the output register, and
//   waits longer while the output is stalled.
// Throughput: one word per cycle unless the output stalls or a clearing pass
//   runs; the read-modify-write of a bin forwards the value just written, so
//   repeated k-mers do not stall. Reset and clear: window and run zeroed at
//   once, then a pass over all 65536 bins (one bin per cycle), in_ready low.
// ----------------------------------------------------------------------------
module kmer_frequency_counter (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [kfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input words
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      command,
    input  logic [7:0]                      symbol,
    input  logic [kfc_pkg::BIN_W-1:0]       bin_index,
    // result words
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            kmer_valid,
    output logic [kfc_pkg::BIN_W-1:0]       kmer_index,
    output logic [kfc_pkg::COUNT_W-1:0]     bin_count
);

    // ---------------- configuration registers ----------------
    logic [7:0]                  base_code_reg [4];
    logic [kfc_pkg::KW_W-1:0]    kmer_width_reg;
    logic                        right_fastest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_code_reg[0]  <= 8'd65;
            base_code_reg[1]  <= 8'd67;
            base_code_reg[2]  <= 8'd71;
            base_code_reg[3]  <= 8'd84;
            kmer_width_reg    <= 4'd8;
            right_fastest_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                kfc_pkg::REG_BASE_0:        base_code_reg[0]  <= cfg_data;
                kfc_pkg::REG_BASE_1:        base_code_reg[1]  <= cfg_data;
                kfc_pkg::REG_BASE_2:        base_code_reg[2]  <= cfg_data;
                kfc_pkg::REG_BASE_3:        base_code_reg[3]  <= cfg_data;
                kfc_pkg::REG_KMER_WIDTH:    kmer_width_reg    <= cfg_data[kfc_pkg::KW_W-1:0];
                kfc_pkg::REG_RIGHT_FASTEST: right_fastest_reg <= cfg_data[0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // ---------------- state ----------------
    logic [kfc_pkg::BIN_W-1:0]   window_reg, window_next;
    logic [kfc_pkg::RUN_W-1:0]   run_reg, run_next;
    logic                        clr_busy_reg, clr_busy_next;
    logic [kfc_pkg::BIN_W-1:0]   clr_addr_reg, clr_addr_next;

    // read stage: one word waiting on its memory read
    logic                        s1_valid_reg, s1_valid_next;
    kfc_pkg::res_kind_t          s1_kind_reg, s1_kind_next;
    logic [kfc_pkg::BIN_W-1:0]   s1_index_reg, s1_index_next;
    // forwarded write that hit the address read at accept time
    logic                        byp_hit_reg, byp_hit_next;
    logic [kfc_pkg::COUNT_W-1:0] byp_data_reg;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic                        kv_reg;
    logic [kfc_pkg::BIN_W-1:0]   kidx_reg;
    logic [kfc_pkg::COUNT_W-1:0] cnt_reg;

    kfc_pkg::mem_req_t           mem_req;
    logic [kfc_pkg::COUNT_W-1:0] mem_rd_data;

    logic                        accept;
    logic                        s1_adv;

    // ---------------- base lookup and window update ----------------
    logic                        base_hit;
    logic [1:0]                  base_val;
    logic [kfc_pkg::KW_W-1:0]    k_eff;
    logic [kfc_pkg::SHIFT_W-1:0] shift;
    logic [kfc_pkg::BIN_W-1:0]   keep;
    logic [kfc_pkg::BIN_W-1:0]   win_shifted;
    logic [kfc_pkg::RUN_W-1:0]   run_inc;
    logic                        count_hit;

    always_comb
    begin
        // highest-numbered matching code wins
        base_hit = 1'b1;
        base_val = 2'd0;
        priority if (symbol == base_code_reg[3]) base_val = 2'd3;
        else if (symbol == base_code_reg[2])     base_val = 2'd2;
        else if (symbol == base_code_reg[1])     base_val = 2'd1;
        else if (symbol == base_code_reg[0])     base_val = 2'd0;
        else                                     base_hit = 1'b0;

        // clamp k into 1..K_MAX
        if (kmer_width_reg == '0)
        begin
            k_eff = kfc_pkg::KW_W'(1);
        end
        else if (kmer_width_reg > kfc_pkg::KW_W'(kfc_pkg::K_MAX))
        begin
            k_eff = kfc_pkg::KW_W'(kfc_pkg::K_MAX);
        end
        else
        begin
            k_eff = kmer_width_reg;
        end

        shift = kfc_pkg::SHIFT_W'(k_eff - kfc_pkg::KW_W'(1)) << 1;
        keep  = (kfc_pkg::BIN_W'(1) << shift) - kfc_pkg::BIN_W'(1);

        if (right_fastest_reg)
        begin
            win_shifted = ((window_reg & keep) << 2) | kfc_pkg::BIN_W'(base_val);
        end
        else
        begin
            win_shifted = ((window_reg & (keep << 2)) >> 2)
                        | (kfc_pkg::BIN_W'(base_val) << shift);
        end

        run_inc   = (run_reg == '1) ? run_reg : run_reg + kfc_pkg::RUN_W'(1);
        count_hit = base_hit && (run_inc >= k_eff);
    end

    // ---------------- read stage result ----------------
    logic [kfc_pkg::COUNT_W-1:0] cur_count;
    logic [kfc_pkg::COUNT_W-1:0] inc_count;
    logic                        res_kv;
    logic [kfc_pkg::BIN_W-1:0]   res_idx;
    logic [kfc_pkg::COUNT_W-1:0] res_cnt;

    always_comb
    begin
        cur_count = byp_hit_reg ? byp_data_reg : mem_rd_data;
        inc_count = (cur_count == '1) ? cur_count : cur_count + kfc_pkg::COUNT_W'(1);
        res_kv  = 1'b0;
        res_idx = '0;
        res_cnt = '0;
        unique case (s1_kind_reg)
            kfc_pkg::RES_COUNT:
            begin
                res_kv  = 1'b1;
                res_idx = s1_index_reg;
                res_cnt = inc_count;
            end
            kfc_pkg::RES_READ:
            begin
                res_idx = s1_index_reg;
                res_cnt = cur_count;
            end
            default: ;  // zero result: miss, clear or unused command
        endcase
    end

    // ---------------- handshake and control ----------------
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clr_busy_reg && (!s1_valid_reg || s1_adv);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        window_next    = window_reg;
        run_next       = run_reg;
        clr_busy_next  = clr_busy_reg;
        clr_addr_next  = clr_addr_reg;
        s1_valid_next  = s1_valid_reg;
        s1_kind_next   = s1_kind_reg;
        s1_index_next  = s1_index_reg;
        out_valid_next = out_valid_reg;

        // sweep the bin store one entry per cycle
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + kfc_pkg::BIN_W'(1);
            if (clr_addr_reg == '1)
            begin
                clr_busy_next = 1'b0;
            end
        end

        if (s1_adv)
        begin
            s1_valid_next  = 1'b0;
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_kind_next  = kfc_pkg::RES_ZERO;
            s1_index_next = '0;
            unique case (command)
                kfc_pkg::CMD_COUNT:
                begin
                    if (base_hit)
                    begin
                        run_next    = run_inc;
                        window_next = win_shifted;
                        if (count_hit)
                        begin
                            s1_kind_next  = kfc_pkg::RES_COUNT;
                            s1_index_next = win_shifted;
                        end
                    end
                    else
                    begin
                        // break the run, keep the window
                        run_next = '0;
                    end
                end
                kfc_pkg::CMD_READ:
                begin
                    s1_kind_next  = kfc_pkg::RES_READ;
                    s1_index_next = bin_index;
                end
                kfc_pkg::CMD_CLEAR:
                begin
                    window_next   = '0;
                    run_next      = '0;
                    clr_busy_next = 1'b1;
                    clr_addr_next = '0;
                end
                default: ;  // unused command: no effect
            endcase
        end
    end

    // ---------------- memory requests ----------------
    always_comb
    begin
        mem_req.rd_en   = accept;
        mem_req.rd_addr = s1_index_next;
        if (clr_busy_reg)
        begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_addr_reg;
            mem_req.wr_data = '0;
        end
        else
        begin
            mem_req.wr_en   = s1_adv && (s1_kind_reg == kfc_pkg::RES_COUNT);
            mem_req.wr_addr = s1_index_reg;
            mem_req.wr_data = inc_count;
        end
        // the array returns the old value when read and written together
        byp_hit_next = accept && mem_req.wr_en && (mem_req.wr_addr == mem_req.rd_addr);
    end

    kfc_bin_store u_bins (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            run_reg       <= '0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s1_kind_reg   <= kfc_pkg::RES_ZERO;
            byp_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            run_reg       <= run_next;
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            s1_kind_reg   <= s1_kind_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                byp_hit_reg <= byp_hit_next;
            end
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        s1_index_reg <= s1_index_next;
        if (accept)
        begin
            byp_data_reg <= mem_req.wr_data;
        end
        if (s1_adv)
        begin
            kv_reg   <= res_kv;
            kidx_reg <= res_idx;
            cnt_reg  <= res_cnt;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kmer_valid = kv_reg;
    assign kmer_index = kidx_reg;
    assign bin_count  = cnt_reg;

endmodule

// ===== rtl/core/kfc_bin_store.sv =====
// ----------------------------------------------------------------------------
// kfc_bin_store: bin counter memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kfc_bin_store (
    input  logic                         clk,
    input  kfc_pkg::mem_req_t            req,
    output logic [kfc_pkg::COUNT_W-1:0]  rd_data
);

    logic [kfc_pkg::COUNT_W-1:0] mem [kfc_pkg::NUM_BINS];
    logic [kfc_pkg::COUNT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/kfc_checker.sv =====
// ----------------------------------------------------------------------------
// kfc_checker: port-level checks for the k-mer frequency counter
// Watches the top-level ports only; attached by the bind at the end.
// ----------------------------------------------------------------------------
module kfc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [1:0]                      command,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            kmer_valid,
    input  logic [kfc_pkg::BIN_W-1:0]       kmer_index,
    input  logic [kfc_pkg::COUNT_W-1:0]     bin_count
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kmer_valid)
            && $stable(kmer_index) && $stable(bin_count))
        else $error("result word changed while stalled");

    // an incremented bin never reports zero
    a_inc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kmer_valid |-> bin_count != '0)
        else $error("incremented bin reported zero");

    // a clear starts the sweep, so no word is taken right after it
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == kfc_pkg::CMD_CLEAR |=> !in_ready)
        else $error("input taken during clearing pass");

    // leaving reset, the sweep is running
    a_reset_sweep: assert property (@(posedge clk)
        $rose(rst_n) |-> !in_ready && !out_valid)
        else $error("block ready before clearing pass");

endmodule

bind kmer_frequency_counter kfc_checker u_kfc_checker (.*);

// ===== bench/tb_kmer_frequency_counter.sv =====
// ----------------------------------------------------------------------------
// tb_kmer_frequency_counter: self-checking bench for the k-mer counter
// Drives command words through the valid/ready input, predicts every result
// word with a behavioral copy of the counter and compares each accepted
// result field by field. Runs a short directed sequence and then randomized
// phases across base code, word length and packing order settings, with
// sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_kmer_frequency_counter;

    // Command code the block must ignore (still answers with an all-zero word)
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One result word as the block should present it
    typedef struct {
        logic                        kv;
        logic [kfc_pkg::BIN_W-1:0]   ki;
        logic [kfc_pkg::COUNT_W-1:0] bc;
    } kmer_result_t;

    // Behavioral copy of the counter plus the queue of awaited result words
    class kmer_tally_board;
        logic [7:0]                  base_code [4];
        logic [kfc_pkg::KW_W-1:0]    kmer_width;
        logic                        right_fastest;
        logic [kfc_pkg::BIN_W-1:0]   window;
        logic [kfc_pkg::RUN_W-1:0]   run_len;
        logic [kfc_pkg::COUNT_W-1:0] bin_tally [logic [kfc_pkg::BIN_W-1:0]];
        logic [kfc_pkg::BIN_W-1:0]   recent_bins [$];
        kmer_result_t                awaited_results [$];
        int                          errors = 0;

        function void reset_state();
            base_code     = '{8'd65, 8'd67, 8'd71, 8'd84};
            kmer_width    = 4'd8;
            right_fastest = 1'b1;
            clear_bins();
        endfunction

        function void clear_bins();
            bin_tally.delete();
            window  = '0;
            run_len = '0;
        endfunction

        function void set_reg(logic [kfc_pkg::CFG_IDX_W-1:0] idx,
                              logic [kfc_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                kfc_pkg::REG_BASE_0, kfc_pkg::REG_BASE_1,
                kfc_pkg::REG_BASE_2, kfc_pkg::REG_BASE_3:
                    base_code[idx[1:0]] = val;
                kfc_pkg::REG_KMER_WIDTH:    kmer_width = val[kfc_pkg::KW_W-1:0];
                kfc_pkg::REG_RIGHT_FASTEST: right_fastest = val[0];
                default: ;
            endcase
        endfunction

        // Advance the copy by one accepted word and queue the result it causes
        function void predict_word(logic [1:0] cmd, logic [7:0] sym,
                                   logic [kfc_pkg::BIN_W-1:0] idx);
            kmer_result_t                r;
            int unsigned                 k;
            int unsigned                 shift;
            int unsigned                 keep;
            int unsigned                 next_win;
            int                          b;
            logic [kfc_pkg::COUNT_W-1:0] count;
            r = '{1'b0, '0, '0};
            case (cmd)
                kfc_pkg::CMD_COUNT:
                begin
                    // clamp word length: 0 acts as 1, above K_MAX acts as K_MAX
                    k = kmer_width;
                    if (k < 1)
                        k = 1;
                    if (k > kfc_pkg::K_MAX)
                        k = kfc_pkg::K_MAX;
                    // highest-numbered matching code wins on duplicates
                    b = -1;
                    for (int i = 3; i >= 0; i--)
                        if (b < 0 && base_code[i] == sym)
                            b = i;
                    if (b < 0)
                        run_len = '0;
                    else
                    begin
                        if (run_len != 4'd15)
                            run_len++;
                        shift = 2 * (k - 1);
                        keep  = (1 << shift) - 1;
                        if (right_fastest)
                            next_win = ((window & keep) << 2) + b;
                        else
                            next_win = ((window & (keep << 2)) >> 2) + (b << shift);
                        window = next_win[kfc_pkg::BIN_W-1:0];
                        if (run_len >= k)
                        begin
                            count = bin_tally.exists(window) ? bin_tally[window] : '0;
                            if (count != '1)
                                count++;
                            bin_tally[window] = count;
                            r = '{1'b1, window, count};
                            recent_bins.push_back(window);
                            if (recent_bins.size() > 16)
                                void'(recent_bins.pop_front());
                        end
                    end
                end
                kfc_pkg::CMD_READ:
                    r = '{1'b0, idx, bin_tally.exists(idx) ? bin_tally[idx] : '0};
                kfc_pkg::CMD_CLEAR:
                    clear_bins();
                default: ;
            endcase
            awaited_results.push_back(r);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task check_word(logic kv, logic [kfc_pkg::BIN_W-1:0] ki,
                        logic [kfc_pkg::COUNT_W-1:0] bc);
            kmer_result_t want;
            if (awaited_results.size() == 0)
            begin
                report($sformatf("unexpected word kmer_valid=%0b index=%h count=%h",
                                 kv, ki, bc));
                return;
            end
            want = awaited_results.pop_front();
            if (kv !== want.kv)
                report($sformatf("kmer_valid %0b, want %0b", kv, want.kv));
            if (ki !== want.ki)
                report($sformatf("kmer_index %h, want %h", ki, want.ki));
            if (bc !== want.bc)
                report($sformatf("bin_count %h, want %h", bc, want.bc));
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [kfc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [kfc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [1:0]                     command = kfc_pkg::CMD_COUNT;
    logic [7:0]                     symbol = '0;
    logic [kfc_pkg::BIN_W-1:0]      bin_index = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic                           kmer_valid;
    logic [kfc_pkg::BIN_W-1:0]      kmer_index;
    logic [kfc_pkg::COUNT_W-1:0]    bin_count;

    // Percent of cycles the sender idles / the receiver stalls in this phase
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    // Long receiver hold-off: main asks, receiver process counts it down
    int hold_request = 0;
    int hold_left = 0;

    kmer_tally_board tally;

    kmer_frequency_counter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .symbol     (symbol),
        .bin_index  (bin_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kmer_valid (kmer_valid),
        .kmer_index (kmer_index),
        .bin_count  (bin_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: drop ready at random, or for a whole hold-off when asked
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else
            out_ready = ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Check every result word on the edge that accepts it
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            tally.check_word(kmer_valid, kmer_index, bin_count);

    // Offer one word and hold it until accepted. Enter and leave at a falling
    // edge; valid stays high on return so back-to-back words need no gap.
    task send_word(input logic [1:0] cmd, input logic [7:0] sym,
                   input logic [kfc_pkg::BIN_W-1:0] idx);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        command   = cmd;
        symbol    = sym;
        bin_index = idx;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        tally.predict_word(cmd, sym, idx);
        @(negedge clk);
    endtask

    // Mostly counts of configured bases, some noise bytes, reads of bins
    // that were just hit or of any bin, and a few unused commands
    task send_random_word();
        int                        pick;
        logic [1:0]                cmd;
        logic [7:0]                sym;
        logic [kfc_pkg::BIN_W-1:0] idx;
        pick = $urandom_range(0, 99);
        sym  = 8'($urandom_range(0, 255));
        idx  = kfc_pkg::BIN_W'($urandom_range(0, 65535));
        if (pick < 3)
            cmd = CMD_UNUSED;
        else if (pick < 16)
        begin
            cmd = kfc_pkg::CMD_READ;
            if (tally.recent_bins.size() != 0 && $urandom_range(0, 1))
                idx = tally.recent_bins[$urandom_range(0, tally.recent_bins.size() - 1)];
        end
        else
        begin
            cmd = kfc_pkg::CMD_COUNT;
            if ($urandom_range(0, 99) >= 6)
                sym = tally.base_code[$urandom_range(0, 3)];
        end
        send_word(cmd, sym, idx);
    endtask

    // Drop valid and wait for every awaited word plus the pipeline tail
    task settle();
        in_valid = 1'b0;
        while (tally.awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all six registers, one per cycle, while the block is idle
    task program_regs(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                      input logic [7:0] b3, input logic [3:0] k, input logic rf);
        logic [kfc_pkg::CFG_DATA_W-1:0] vals [6];
        vals = '{b0, b1, b2, b3, {4'd0, k}, {7'd0, rf}};
        for (int i = kfc_pkg::REG_BASE_0; i <= kfc_pkg::REG_RIGHT_FASTEST; i++)
        begin
            cfg_wr_en = 1'b1;
            cfg_index = i[kfc_pkg::CFG_IDX_W-1:0];
            cfg_data  = vals[i];
            tally.set_reg(i[kfc_pkg::CFG_IDX_W-1:0], vals[i]);
            @(negedge clk);
        end
        cfg_wr_en = 1'b0;
    endtask

    // One random phase: settle, reprogram, optionally clear, then stream words
    task run_phase(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                   input logic [7:0] b3, input logic [3:0] k, input logic rf,
                   input int tx_pct, input int rx_pct, input bit clear_first,
                   input bit pressure, input int words);
        settle();
        program_regs(b0, b1, b2, b3, k, rf);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (clear_first)
            send_word(kfc_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)),
                      kfc_pkg::BIN_W'($urandom_range(0, 65535)));
        for (int n = 0; n < words; n++)
        begin
            // hold the receiver off while the sender keeps pushing, so the
            // block fills up and must stall its input
            if (pressure && n == 20)
                hold_request = 400;
            send_random_word();
        end
    endtask

    initial
    begin
        tally = new;
        tally.reset_state();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: default codes, k = 8, newest base low. Nine T bases fill
        // the window to the top bin and hit it twice.
        repeat (9) send_word(kfc_pkg::CMD_COUNT, 8'd84, 16'h0000);
        send_word(kfc_pkg::CMD_READ, 8'h00, 16'hFFFF);
        send_word(kfc_pkg::CMD_READ, 8'hFF, 16'h0000);
        // non-base bytes break the run without an increment
        send_word(kfc_pkg::CMD_COUNT, 8'h00, 16'hFFFF);
        send_word(kfc_pkg::CMD_COUNT, 8'hFF, 16'h0000);
        // unused command answers with zeros and changes nothing
        send_word(CMD_UNUSED, 8'hFF, 16'hFFFF);
        // clear, then the top bin must read back as zero
        send_word(kfc_pkg::CMD_CLEAR, 8'hFF, 16'hFFFF);
        send_word(kfc_pkg::CMD_READ, 8'h00, 16'hFFFF);
        // single-base words: every base counts at once into its own bin
        settle();
        program_regs(8'd65, 8'd67, 8'd71, 8'd84, 4'd1, 1'b1);
        send_word(kfc_pkg::CMD_COUNT, 8'd65, 16'h0000);
        send_word(kfc_pkg::CMD_COUNT, 8'd67, 16'h0000);
        send_word(kfc_pkg::CMD_COUNT, 8'd71, 16'h0000);
        send_word(kfc_pkg::CMD_COUNT, 8'd84, 16'h0000);
        send_word(kfc_pkg::CMD_READ, 8'h00, 16'h0003);

        // Random phases; word length and packing change without clearing so
        // the window carries over between settings
        run_phase(8'd65, 8'd67, 8'd71, 8'd84, 4'd8, 1'b1, 0, 0, 1'b0, 1'b1, 100);
        run_phase(8'd65, 8'd67, 8'd71, 8'd84, 4'd1, 1'b0, 74, 0, 1'b0, 1'b0, 100);
        run_phase(8'h00, 8'hFF, 8'h80, 8'h01, 4'd3, 1'b1, 0, 74, 1'b0, 1'b0, 100);
        // zero word length acts as one
        run_phase(8'd65, 8'd67, 8'd71, 8'd84, 4'd0, 1'b0, 27, 27, 1'b1, 1'b0, 100);
        // duplicate codes, and an oversized word length that acts as K_MAX
        run_phase(8'd97, 8'd97, 8'd99, 8'd99, 4'd15, 1'b0, 0, 0, 1'b0, 1'b0, 100);
        run_phase(8'd65, 8'd67, 8'd71, 8'd84, 4'd12, 1'b1, 74, 0, 1'b0, 1'b0, 100);
        run_phase(8'd103, 8'd116, 8'd103, 8'd116, 4'd5, 1'b0, 0, 74, 1'b1, 1'b0, 100);
        run_phase(8'd65, 8'd67, 8'd71, 8'd84, 4'd2, 1'b1, 27, 27, 1'b0, 1'b0, 100);
        run_phase(8'd84, 8'd71, 8'd67, 8'd65, 4'd8, 1'b0, 0, 0, 1'b1, 1'b0, 100);

        // Drain with the receiver always ready, then watch for stray words
        in_valid = 1'b0;
        rx_stall_pct = 0;
        while (tally.awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (tally.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: covers the clearing passes after reset and each clear
    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
